/* hw/rtl/bca_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bca_pkg
// shared types, codes and bit helpers of the bitmap cluster allocator
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam logic [7:0] FIRST_BIT = 8'b1000_0000;
  localparam logic [7:0] LAST_BIT  = 8'b0000_0001;
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam int         CFG_W           = 10;
  localparam int         PADDR_W         = 2;
  localparam logic [9:0] CFG_BYTES_RESET = 10'd512;
  localparam logic [1:0] ADDR_BYTES_USED = 2'd0;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_MARK_SET = 2'd1,
    OP_MARK_CLR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    PUSH_CLUSTER = 2'd0,
    PUSH_ECHO    = 2'd1,
    PUSH_ZERO    = 2'd2,
    PUSH_FAIL    = 2'd3
  } push_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FETCH,
    ST_PICK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_ZERO,
    ST_FAIL
  } ctrl_state_t;

  typedef struct packed {
    logic      load_req;
    logic      clear_step;
    logic      scan_step;
    logic      rewind;
    logic      fetch;
    logic      take_bit;
    logic      write_back;
    logic      mark_rd;
    logic      mark_wr;
    logic      push;
    push_sel_t sel;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    need_zero;
    logic    need_over;
    logic    enough;
    logic    scan_end;
    logic    work_full;
    logic    last_bit;
    logic    out_space;
    logic    clear_last;
  } sts_t;

  // number of free (zero) bits in a bitmap byte
  function automatic logic [3:0] count_free(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, ~v[i]};
    end
    return n;
  endfunction

  // position of the first free bit, msb first
  function automatic logic [2:0] first_free(input logic [7:0] v);
    logic [2:0] pos;
    logic       hit;
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && !v[7 - i]) begin
        pos = 3'(i);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/bitmap_cluster_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_cluster_allocator
// free-space bitmap allocator: allocate free clusters, not necessarily contiguous, mark bits
//
//   channel   signals                               transaction
//   req       req_valid/req_ready                   opcode, need_count,
//                                                   cluster_index
//   rsp       rsp_valid/rsp_ready                   cluster_out, status, last
//   apb       psel/penable/pwrite/paddr/pwdata      bitmap_bytes_used at 0x0
//
// after reset a clearing pass writes zero to every bitmap byte, during which
// req_ready stays low; apb writes are taken throughout.
// mark ops read the bitmap byte, then write it back and push the echo; allocate
// walks the bitmap once to count free bits, one byte a cycle, and once to emit.
// one request at a time; a finished result waits in the output register
// while the next request is taken, and rsp stalls hold the emit pass.
// ----------------------------------------------------------------------------
module bitmap_cluster_allocator #(
  parameter int MAP_BYTES   = 512,
  parameter int MAX_REQUEST = 64
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  wire  [1:0]                     opcode,
  input  wire  [6:0]                     need_count,
  input  wire  [11:0]                    cluster_index,
  output logic                           rsp_valid,
  input  wire                            rsp_ready,
  output logic [11:0]                    cluster_out,
  output logic                           status,
  output logic                           last,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [bca_pkg::PADDR_W-1:0]    paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bca_pkg::*;

  logic [CFG_W-1:0] bytes_used;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BYTES_USED) ? 32'(bytes_used) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_used <= CFG_BYTES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_BYTES_USED)) begin
      bytes_used <= pwdata[CFG_W-1:0];
    end
  end

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bca_datapath #(
    .MAP_BYTES   (MAP_BYTES),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .opcode          (opcode),
    .need_count      (need_count),
    .cluster_index   (cluster_index),
    .cfg_bytes_used  (bytes_used),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .cluster_out     (cluster_out),
    .status          (status),
    .last            (last)
  );

endmodule
`default_nettype wire

/* hw/rtl/bca_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bca_ctrl
// sequencer: bitmap clear, request decode, count pass, emit pass, mark ops
// ----------------------------------------------------------------------------
module bca_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_ready,
  input  bca_pkg::sts_t   sts,
  output bca_pkg::cmd_t   cmd
);
  import bca_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_ALLOC: begin
            if (sts.need_zero) begin
              state_next = ST_ZERO;
            end else if (sts.need_over) begin
              state_next = ST_FAIL;
            end else begin
              state_next = ST_SCAN;
            end
          end
          OP_MARK_SET, OP_MARK_CLR: begin
            state_next = ST_MARK_RD;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.enough) begin
          cmd.rewind = 1'b1;
          state_next = ST_FETCH;
        end else if (sts.scan_end) begin
          state_next = ST_FAIL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (sts.work_full) begin
          cmd.write_back = 1'b1;
          cmd.fetch      = 1'b1;
        end else if (sts.out_space) begin
          cmd.take_bit   = 1'b1;
          cmd.write_back = 1'b1;
          cmd.push       = 1'b1;
          cmd.sel        = PUSH_CLUSTER;
          if (sts.last_bit) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_next  = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        if (sts.out_space) begin
          cmd.mark_wr = 1'b1;
          cmd.push    = 1'b1;
          cmd.sel     = PUSH_ECHO;
          state_next  = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (sts.out_space) begin
          cmd.push   = 1'b1;
          cmd.sel    = PUSH_ZERO;
          state_next = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (sts.out_space) begin
          cmd.push   = 1'b1;
          cmd.sel    = PUSH_FAIL;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_push_has_space: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_space)
    else $error("result pushed into a full output register");

  a_fail_only_after_scan_or_decode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FAIL) |-> ($past(state) == ST_FAIL || $past(state) == ST_SCAN
                            || $past(state) == ST_DECODE))
    else $error("failure result without a finished count pass");

endmodule
`default_nettype wire

/* hw/rtl/bca_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bca_datapath
// bitmap memory, scan pointer, free counters, bit picker and output register
// ----------------------------------------------------------------------------
module bca_datapath #(
  parameter int MAP_BYTES   = 512,
  parameter int MAX_REQUEST = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  [1:0]                   opcode,
  input  wire  [6:0]                   need_count,
  input  wire  [11:0]                  cluster_index,
  input  wire  [bca_pkg::CFG_W-1:0]    cfg_bytes_used,
  input  bca_pkg::cmd_t                cmd,
  output bca_pkg::sts_t                sts,
  output logic                         rsp_valid,
  input  wire                          rsp_ready,
  output logic [11:0]                  cluster_out,
  output logic                         status,
  output logic                         last
);
  import bca_pkg::*;

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CW = $clog2(MAP_BYTES + 1);
  localparam int FW = $clog2(MAX_REQUEST + 9);

  logic [7:0]    mem [MAP_BYTES];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  opcode_t       opcode_q;
  logic [6:0]    needed_q;
  logic [11:0]   index_q;
  logic [CW-1:0] byte_ptr;
  logic [CW-1:0] limit;
  logic [31:0]   cfg_ext;
  logic [AW-1:0] ptr_addr;
  logic [AW-1:0] wb_addr;
  logic [FW-1:0] found;
  logic [FW-1:0] emitted;
  logic          pend;
  logic          fresh;
  logic [7:0]    cur;
  logic [7:0]    working;
  logic [2:0]    pos;
  logic [7:0]    bit_mask;
  logic          enough;
  logic          scan_go;
  logic          last_bit;
  logic          out_space;
  logic [31:0]   mark_byte;
  logic          mark_in_map;
  logic [AW-1:0] mark_addr;
  logic [7:0]    mark_mask;
  logic [31:0]   clus_wide;

  assign cfg_ext   = 32'(cfg_bytes_used);
  assign limit     = (cfg_ext > MAP_BYTES) ? CW'(MAP_BYTES) : cfg_ext[CW-1:0];
  assign ptr_addr  = byte_ptr[AW-1:0];

  assign mark_byte   = 32'(index_q[11:3]);
  assign mark_in_map = mark_byte < MAP_BYTES;
  assign mark_addr   = mark_byte[AW-1:0];
  assign mark_mask   = FIRST_BIT >> index_q[2:0];

  assign enough    = 32'(found) >= 32'(needed_q);
  assign scan_go   = cmd.scan_step && (byte_ptr < limit) && !enough;
  assign working   = fresh ? rd_data : cur;
  assign pos       = first_free(working);
  assign bit_mask  = FIRST_BIT >> pos;
  assign last_bit  = (32'(emitted) + 32'd1) == 32'(needed_q);
  assign out_space = !rsp_valid || rsp_ready;
  assign clus_wide = 32'({wb_addr, pos});

  // memory ports
  assign rd_en   = scan_go | cmd.fetch | cmd.mark_rd;
  assign rd_addr = cmd.mark_rd ? mark_addr : ptr_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_addr;
    wr_data = '0;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.write_back) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr;
      wr_data = cmd.take_bit ? (working | bit_mask) : working;
    end else if (cmd.mark_wr) begin
      wr_en   = mark_in_map;
      wr_addr = mark_addr;
      wr_data = (opcode_q == OP_MARK_SET) ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request capture and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_ptr <= '0;
      found    <= '0;
      emitted  <= '0;
      needed_q <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= scan_go;
      if (cmd.load_req || cmd.rewind) begin
        byte_ptr <= '0;
      end else if (cmd.clear_step || scan_go || cmd.fetch) begin
        byte_ptr <= byte_ptr + 1'b1;
      end
      if (cmd.load_req) begin
        needed_q <= need_count;
        found    <= '0;
        emitted  <= '0;
      end else begin
        if (pend && !enough) begin
          found <= found + FW'(count_free(rd_data));
        end
        if (cmd.take_bit) begin
          emitted <= emitted + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      opcode_q <= opcode_t'(opcode);
      index_q  <= cluster_index;
    end
    if (cmd.fetch) begin
      wb_addr <= ptr_addr;
    end
    if (cmd.take_bit) begin
      cur <= working | bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
    end else if (cmd.fetch) begin
      fresh <= 1'b1;
    end else if (cmd.take_bit) begin
      fresh <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.sel)
        PUSH_CLUSTER: begin
          cluster_out <= clus_wide[11:0];
          status      <= 1'b0;
          last        <= last_bit;
        end
        PUSH_ECHO: begin
          cluster_out <= index_q;
          status      <= 1'b0;
          last        <= 1'b1;
        end
        PUSH_ZERO: begin
          cluster_out <= '0;
          status      <= 1'b0;
          last        <= 1'b1;
        end
        default: begin
          cluster_out <= '0;
          status      <= 1'b1;
          last        <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts            = '0;
    sts.op         = opcode_q;
    sts.need_zero  = needed_q == '0;
    sts.need_over  = 32'(needed_q) > MAX_REQUEST;
    sts.enough     = enough;
    sts.scan_end   = !pend && (byte_ptr >= limit);
    sts.work_full  = working == FULL_BYTE;
    sts.last_bit   = last_bit;
    sts.out_space  = out_space;
    sts.clear_last = 32'(byte_ptr) == (MAP_BYTES - 1);
  end

  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("bitmap read and write hit the same byte");

  a_found_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(found) <= 32'(needed_q) + 32'd7)
    else $error("free count ran past the request");

  a_emit_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(emitted) <= 32'(needed_q))
    else $error("more clusters emitted than requested");

endmodule
`default_nettype wire
